[hdl/baro_sensor_compensation_filter_macros.svh]
// assertion macros shared by the compensation filter modules
`ifndef BARO_SENSOR_COMPENSATION_FILTER_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_FILTER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSCF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bscf_pkg.sv]
// types and constants of the barometric compensation filter
`timescale 1ns / 1ps
package bscf_pkg;

	// field widths
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int TEMP_W  = 19;
	localparam int P_W     = 24;
	localparam int CFG_IDX_W = 3;

	// internal arithmetic widths
	localparam int DT_W    = 25;
	localparam int OFF_W   = 36;
	localparam int SENS_W  = 35;
	localparam int SENS_LO_W = 18;
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 59;
	localparam int TFULL_W = 23;
	localparam int Q_FRAC  = 3;
	localparam int STATE_W = P_W + Q_FRAC;

	// scaling constants
	localparam int OFF_SHIFT  = 6;
	localparam int SENS_SHIFT = 7;
	localparam int TEMP_SHIFT = 23;
	localparam int P_SHIFT1   = 21;
	localparam int P_SHIFT2   = 15;
	localparam int TEMP_BASE  = 2000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENS          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN     = 3'd6;

	// per-step commands from controller to datapath
	typedef struct packed {
		logic ld_in;
		logic calc_dt;
		logic mul_off;
		logic mul_sens;
		logic mul_temp;
		logic mul_plo;
		logic mul_phi;
		logic sum_p;
		logic res_p;
		logic fin;
	} cmd_t;

endpackage

[hdl/bscf_ctrl.sv]
// sequencer for the compensation steps and output handshake
`timescale 1ns / 1ps
`include "baro_sensor_compensation_filter_macros.svh"
module bscf_ctrl import bscf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DT    = 10'b0000000010,
		ST_MOFF  = 10'b0000000100,
		ST_MSENS = 10'b0000001000,
		ST_MTEMP = 10'b0000010000,
		ST_MPLO  = 10'b0000100000,
		ST_MPHI  = 10'b0001000000,
		ST_PSUM  = 10'b0010000000,
		ST_PRES  = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_n = ST_DT;
			ST_DT:    state_n = ST_MOFF;
			ST_MOFF:  state_n = ST_MSENS;
			ST_MSENS: state_n = ST_MTEMP;
			ST_MTEMP: state_n = ST_MPLO;
			ST_MPLO:  state_n = ST_MPHI;
			ST_MPHI:  state_n = ST_PSUM;
			ST_PSUM:  state_n = ST_PRES;
			ST_PRES:  state_n = ST_FIN;
			ST_FIN:   if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.ld_in    = (state_q == ST_IDLE) && in_valid;
		cmd.calc_dt  = (state_q == ST_DT);
		cmd.mul_off  = (state_q == ST_MOFF);
		cmd.mul_sens = (state_q == ST_MSENS);
		cmd.mul_temp = (state_q == ST_MTEMP);
		cmd.mul_plo  = (state_q == ST_MPLO);
		cmd.mul_phi  = (state_q == ST_MPHI);
		cmd.sum_p    = (state_q == ST_PSUM);
		cmd.res_p    = (state_q == ST_PRES);
		cmd.fin      = (state_q == ST_FIN) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BSCF_ASSERT_NEXT(a_accept_starts, cmd.ld_in, state_q == ST_DT,
		"accepted transfer did not start the sequence")
	`BSCF_ASSERT_NEXT(a_fin_holds, (state_q == ST_FIN) && out_valid_q && !out_ready,
		state_q == ST_FIN, "result overwrote a pending transfer")
	`BSCF_ASSERT_NEXT(a_fin_valid, cmd.fin, out_valid_q,
		"finished result not presented")

endmodule

[hdl/bscf_datapath.sv]
// registers, shared multiplier and filter of the compensation datapath
`timescale 1ns / 1ps
`include "baro_sensor_compensation_filter_macros.svh"
module bscf_datapath import bscf_pkg::*; #(
	parameter int FILTER_SHIFT = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [COEF_W-1:0]        cfg_wdata,
	input  cmd_t                     cmd,
	input  logic [RAW_W-1:0]         raw_pressure,
	input  logic [RAW_W-1:0]         raw_temperature,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic signed [P_W-1:0]    pressure_centi
);

	// configuration registers
	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic              filt_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0; c2_q <= '0; c3_q <= '0;
			c4_q <= '0; c5_q <= '0; c6_q <= '0;
			filt_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SENS:          c1_q <= cfg_wdata;
				REG_OFFSET:        c2_q <= cfg_wdata;
				REG_SENS_TEMPCO:   c3_q <= cfg_wdata;
				REG_OFFSET_TEMPCO: c4_q <= cfg_wdata;
				REG_REF_TEMP:      c5_q <= cfg_wdata;
				REG_TEMP_SLOPE:    c6_q <= cfg_wdata;
				REG_FILTER_EN:     filt_en_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// working registers
	logic [RAW_W-1:0]          d1_q, d2_q;
	logic signed [DT_W-1:0]    dt_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [SENS_W-1:0]  sens_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [P_W-1:0]     p_q;
	logic signed [STATE_W-1:0] filt_q;
	logic                      primed_q;
	logic signed [TEMP_W-1:0]  out_temp_q;
	logic signed [P_W-1:0]     out_pres_q;

	// shared multiplier operand select
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	always_comb begin
		mul_a = {{(MUL_A_W-DT_W){dt_q[DT_W-1]}}, dt_q};
		mul_b = {{(MUL_B_W-COEF_W){1'b0}}, c4_q};
		if (cmd.mul_sens) begin
			mul_b = {{(MUL_B_W-COEF_W){1'b0}}, c3_q};
		end else if (cmd.mul_temp) begin
			mul_b = {{(MUL_B_W-COEF_W){1'b0}}, c6_q};
		end else if (cmd.mul_plo) begin
			mul_a = {{(MUL_A_W-RAW_W){1'b0}}, d1_q};
			mul_b = {{(MUL_B_W-SENS_LO_W){1'b0}}, sens_q[SENS_LO_W-1:0]};
		end else if (cmd.mul_phi) begin
			mul_a = {{(MUL_A_W-RAW_W){1'b0}}, d1_q};
			mul_b = {{(MUL_B_W-(SENS_W-SENS_LO_W)){sens_q[SENS_W-1]}},
				sens_q[SENS_W-1:SENS_LO_W]};
		end
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// scaled products
	logic signed [PROD_W-1:0]  prod_sh_off, prod_sh_sens, prod_sh_temp;
	logic signed [OFF_W-1:0]   off_next;
	logic signed [SENS_W-1:0]  sens_next;
	logic signed [TFULL_W-1:0] temp_full;
	logic signed [TEMP_W-1:0]  temp_sat;
	logic signed [DT_W-1:0]    dt_next;

	assign dt_next = $signed({1'b0, d2_q}) - $signed({1'b0, c5_q, 8'b0});
	assign prod_sh_off  = prod_q >>> OFF_SHIFT;
	assign prod_sh_sens = prod_q >>> SENS_SHIFT;
	assign prod_sh_temp = prod_q >>> TEMP_SHIFT;
	assign off_next  = $signed({3'b0, c2_q, 17'b0}) + prod_sh_off[OFF_W-1:0];
	assign sens_next = $signed({3'b0, c1_q, 16'b0}) + prod_sh_sens[SENS_W-1:0];
	assign temp_full = prod_sh_temp[TFULL_W-1:0] + TFULL_W'(TEMP_BASE);

	// temperature saturation to the output range
	always_comb begin
		if (temp_full[TFULL_W-1:TEMP_W-1] == {(TFULL_W-TEMP_W+1){temp_full[TFULL_W-1]}}) begin
			temp_sat = temp_full[TEMP_W-1:0];
		end else if (temp_full[TFULL_W-1]) begin
			temp_sat = {1'b1, {(TEMP_W-1){1'b0}}};
		end else begin
			temp_sat = {1'b0, {(TEMP_W-1){1'b1}}};
		end
	end

	// pressure from the full product
	logic signed [ACC_W-1:0]      acc_hi;
	logic signed [ACC_W-1:0]      acc_sh;
	logic signed [OFF_W+2:0]      p_diff;
	logic signed [OFF_W+2:0]      p_diff_sh;

	assign acc_hi    = {prod_q[ACC_W-SENS_LO_W-1:0], {SENS_LO_W{1'b0}}};
	assign acc_sh    = acc_q >>> P_SHIFT1;
	assign p_diff    = $signed(acc_sh[OFF_W+2:0]) - $signed({{3{off_q[OFF_W-1]}}, off_q});
	assign p_diff_sh = p_diff >>> P_SHIFT2;

	// low-pass filter update
	logic signed [STATE_W-1:0] target, base;
	logic signed [STATE_W:0]   f_diff, f_step, f_new;
	logic signed [STATE_W-1:0] filt_next;
	logic signed [STATE_W-1:0] filt_sh;

	assign target    = {p_q, {Q_FRAC{1'b0}}};
	assign base      = primed_q ? filt_q : target;
	assign f_diff    = {target[STATE_W-1], target} - {base[STATE_W-1], base};
	assign f_step    = f_diff >>> FILTER_SHIFT;
	assign f_new     = {base[STATE_W-1], base} + f_step;
	assign filt_next = f_new[STATE_W-1:0];
	assign filt_sh   = filt_next >>> Q_FRAC;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			d1_q <= raw_pressure;
			d2_q <= raw_temperature;
		end
		if (cmd.calc_dt) dt_q <= dt_next;
		if (cmd.mul_off || cmd.mul_sens || cmd.mul_temp || cmd.mul_plo || cmd.mul_phi) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_sens) off_q <= off_next;
		if (cmd.mul_temp) sens_q <= sens_next;
		if (cmd.mul_plo) temp_q <= temp_sat;
		// low partial product is unsigned and fits its own width
		if (cmd.mul_phi) acc_q <= {{(ACC_W-RAW_W-SENS_LO_W){1'b0}},
			prod_q[RAW_W+SENS_LO_W-1:0]};
		if (cmd.sum_p) acc_q <= acc_q + acc_hi;
		if (cmd.res_p) p_q <= p_diff_sh[P_W-1:0];
		if (cmd.fin) begin
			out_temp_q <= temp_q;
			out_pres_q <= filt_en_q ? filt_sh[P_W-1:0] : p_q;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			primed_q <= 1'b0;
		end else if (cmd.fin && filt_en_q) begin
			filt_q   <= filt_next;
			primed_q <= 1'b1;
		end
	end

	assign temperature_centi = out_temp_q;
	assign pressure_centi    = out_pres_q;

	`BSCF_ASSERT_NEXT(a_primed_stays, primed_q, primed_q,
		"filter lost its primed state")
	`BSCF_ASSERT_NEXT(a_filter_primes, cmd.fin && filt_en_q, primed_q,
		"filtered result left filter unprimed")

endmodule

[hdl/baro_sensor_compensation_filter.sv]
// top level of the barometric sensor compensation filter
//
// channel   direction  signals                          content
// s_axis    in         s_axis_tvalid/tready/tdata       raw pressure, raw temperature
// m_axis    out        m_axis_tvalid/tready/tdata       temperature, pressure
// cfg       in         cfg_valid/cfg_ready/index/data   calibration and filter enable
//
// an item goes through these steps in order: accept, difference step,
// five passes through the one 26x19 multiplier, product sum, pressure, finish
// the finish step waits while a previous result is still pending on m_axis
// reset is asynchronous; it clears config and control registers, filter state and primed flag
// cfg_ready is always high; writes are meant to come only while idle
`timescale 1ns / 1ps
module baro_sensor_compensation_filter import bscf_pkg::*; #(
	parameter int FILTER_SHIFT = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [23:0] raw_pressure, [47:24] raw_temperature
	input  logic [47:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [18:0] temperature_centi, [42:19] pressure_centi, [47:43] zero
	output logic [47:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	cmd_t                     cmd;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [P_W-1:0]    pressure_centi;

	assign cfg_ready = 1'b1;

	// sequencer
	bscf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// arithmetic and state
	bscf_datapath #(
		.FILTER_SHIFT (FILTER_SHIFT)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid),
		.cfg_idx           (cfg_index),
		.cfg_wdata         (cfg_data),
		.cmd               (cmd),
		.raw_pressure      (s_axis_tdata[23:0]),
		.raw_temperature   (s_axis_tdata[47:24]),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

	// output packing
	assign m_axis_tdata = {5'b0, pressure_centi, temperature_centi};

endmodule
